// ----- sv/dcrs_pkg.sv -----
// Package: shared constants, codes and types of the color run segmenter.
`default_nettype none
package dcrs_pkg;

  // Default position width in encoder ticks
  localparam int unsigned POSITION_BITS = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BLOCK = 1'b1;

  localparam logic [7:0]  CONFIRM_RESET = 8'd25;
  localparam logic [15:0] TPB_RESET     = 16'd90;
  localparam logic [15:0] START_BLOCKS  = 16'd3;
  localparam logic [15:0] BLOCKS_MAX    = 16'hFFFF;

  // Command codes on the input channel
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  // Event codes on the result channel
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_RUN   = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  // Sensor color codes
  localparam logic [2:0] COLOR_NONE   = 3'd0;
  localparam logic [2:0] COLOR_BLUE   = 3'd2;
  localparam logic [2:0] COLOR_GREEN  = 3'd3;
  localparam logic [2:0] COLOR_YELLOW = 3'd4;
  localparam logic [2:0] COLOR_RED    = 3'd5;
  localparam logic [2:0] COLOR_WHITE  = 3'd6;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    IK_START,
    IK_SAMPLE,
    IK_STOP
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_t;

  function automatic logic is_run_color(input logic [2:0] c);
    return (c == COLOR_RED) || (c == COLOR_GREEN) || (c == COLOR_BLUE) ||
           (c == COLOR_YELLOW);
  endfunction

endpackage
`default_nettype wire

// ----- sv/dcrs_in_if.sv -----
// Interface: input channel carrying commands, color samples and positions.
`default_nettype none
interface dcrs_in_if #(
  parameter int unsigned POS_BITS = dcrs_pkg::POSITION_BITS
);
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [2:0]          sample_color;
  logic [POS_BITS-1:0] position;

  modport source (output valid, cmd, sample_color, position, input ready);
  modport sink   (input valid, cmd, sample_color, position, output ready);
endinterface
`default_nettype wire

// ----- sv/dcrs_out_if.sv -----
// Interface: result channel carrying start, run and stop events.
`default_nettype none
interface dcrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  run_color;
  logic [15:0] run_blocks;

  modport source (output valid, event_kind, run_color, run_blocks, input ready);
  modport sink   (input valid, event_kind, run_color, run_blocks, output ready);
endinterface
`default_nettype wire

// ----- sv/dcrs_queue.sv -----
// Short FIFO between the front decoder and the back processor.
`default_nettype none
module dcrs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dcrs_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  space,
  input  wire logic             pop,
  output logic                  avail,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign space    = count_r != CNT_W'(DEPTH);
  assign avail    = count_r != '0;
  assign pop_data = mem_r[rptr_r];
  assign do_push  = push && space;
  assign do_pop   = pop && avail;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dcrs_front.sv -----
// Front end: accepts input beats, decodes the command, queues work for the back end.
`default_nettype none
module dcrs_front #(
  parameter int unsigned POSITION_BITS = dcrs_pkg::POSITION_BITS,
  parameter int unsigned ENTRY_W       = $bits(dcrs_pkg::item_kind_t) + 3 + POSITION_BITS
) (
  dcrs_in_if.sink                  in_ch,
  output logic                     q_push,
  output logic [ENTRY_W-1:0]       q_data,
  input  wire logic                q_space
);

  dcrs_pkg::item_kind_t      kind;
  logic                      keep;
  logic [POSITION_BITS-1:0]  pos_ob;

  // Offset binary: flipping the sign bit makes unsigned order match signed order
  assign pos_ob = in_ch.position ^ {1'b1, {(POSITION_BITS-1){1'b0}}};

  always_comb begin
    kind = dcrs_pkg::IK_SAMPLE;
    keep = 1'b1;
    case (in_ch.cmd)
      dcrs_pkg::CMD_START:  kind = dcrs_pkg::IK_START;
      dcrs_pkg::CMD_SAMPLE: kind = dcrs_pkg::IK_SAMPLE;
      dcrs_pkg::CMD_STOP:   kind = dcrs_pkg::IK_STOP;
      default:              keep = 1'b0; // unknown command: beat taken, dropped
    endcase
  end

  assign in_ch.ready = q_space;
  assign q_push      = in_ch.valid && q_space && keep;
  assign q_data      = {kind, in_ch.sample_color, pos_ob};

endmodule
`default_nettype wire

// ----- sv/dcrs_back.sv -----
// Back end: debounce state, sequence control, iterative span divider and result register.
`default_nettype none
module dcrs_back #(
  parameter int unsigned POSITION_BITS = dcrs_pkg::POSITION_BITS,
  parameter int unsigned ENTRY_W       = $bits(dcrs_pkg::item_kind_t) + 3 + POSITION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dcrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            q_avail,
  input  wire logic [ENTRY_W-1:0]              q_data,
  output logic                                 q_pop,
  dcrs_out_if.source                           out_ch
);

  localparam int unsigned PB    = POSITION_BITS;
  localparam int unsigned CNT_W = $clog2(PB);
  localparam int unsigned KW    = $bits(dcrs_pkg::item_kind_t);

  dcrs_pkg::back_state_t state_r, state_nxt;

  logic [7:0]    confirm_r;
  logic [15:0]   tpb_r;
  logic [2:0]    held_r, held_nxt;
  logic [7:0]    rep_r, rep_nxt;
  logic [PB-1:0] ref_r, ref_nxt;
  logic          first_r, first_nxt;
  logic          fin_r, fin_nxt;
  logic [15:0]   div_r, div_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [PB-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]    runc_r, runc_nxt;
  logic [PB-1:0] endpos_r, endpos_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [2:0]    out_color_r, out_color_nxt;
  logic [15:0]   out_blocks_r, out_blocks_nxt;

  dcrs_pkg::item_kind_t q_kind;
  logic [2:0]    q_color;
  logic [PB-1:0] q_pos;
  logic          slot_free;
  logic          start_div;
  logic          emit;
  logic          confirmed;
  logic          changed;
  logic [PB:0]   diff;
  logic [16:0]   trial;
  logic          trial_ge;
  logic          div_last;
  logic          quo_sat;

  assign q_kind  = dcrs_pkg::item_kind_t'(q_data[ENTRY_W-1 -: KW]);
  assign q_color = q_data[PB +: 3];
  assign q_pos   = q_data[PB-1:0];

  assign slot_free = !out_valid_r || out_ch.ready;
  assign confirmed = rep_r >= confirm_r;
  assign changed   = q_color != held_r;
  // pos > ref exactly when no borrow and a nonzero span
  assign diff      = {1'b0, q_pos} - {1'b0, ref_r};

  // One restoring divider step per cycle, dividend bits shifted out of quo_r
  assign trial    = {rem_r, quo_r[PB-1]};
  assign trial_ge = trial >= {1'b0, div_r};
  assign div_last = cnt_r == CNT_W'(PB - 1);
  assign quo_sat  = (quo_r >> 16) != '0;

  assign q_pop = (state_r == dcrs_pkg::BK_IDLE) && q_avail && slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dcrs_pkg::BK_IDLE: begin
        if (start_div) begin
          state_nxt = dcrs_pkg::BK_DIVIDE;
        end
      end
      dcrs_pkg::BK_DIVIDE: begin
        if (div_last) begin
          state_nxt = dcrs_pkg::BK_DONE;
        end
      end
      dcrs_pkg::BK_DONE: begin
        if (quo_r == '0 || slot_free) begin
          state_nxt = dcrs_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dcrs_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    held_nxt       = held_r;
    rep_nxt        = rep_r;
    ref_nxt        = ref_r;
    first_nxt      = first_r;
    fin_nxt        = fin_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    runc_nxt       = runc_r;
    endpos_nxt     = endpos_r;
    start_div      = 1'b0;
    emit           = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_color_nxt  = out_color_r;
    out_blocks_nxt = out_blocks_r;

    case (state_r)
      dcrs_pkg::BK_IDLE: begin
        if (q_pop) begin
          case (q_kind)
            dcrs_pkg::IK_START: begin
              held_nxt       = dcrs_pkg::COLOR_NONE;
              rep_nxt        = '0;
              ref_nxt        = q_pos;
              first_nxt      = 1'b0;
              fin_nxt        = 1'b0;
              emit           = 1'b1;
              out_kind_nxt   = dcrs_pkg::EV_START;
              out_color_nxt  = dcrs_pkg::COLOR_WHITE;
              out_blocks_nxt = dcrs_pkg::START_BLOCKS;
            end
            dcrs_pkg::IK_STOP: begin
              if (!fin_r) begin
                fin_nxt        = 1'b1;
                emit           = 1'b1;
                out_kind_nxt   = dcrs_pkg::EV_STOP;
                out_color_nxt  = dcrs_pkg::COLOR_NONE;
                out_blocks_nxt = '0;
              end
            end
            dcrs_pkg::IK_SAMPLE: begin
              if (!fin_r) begin
                if (!changed) begin
                  if (rep_r < confirm_r) begin
                    rep_nxt = rep_r + 1'b1;
                  end
                end else begin
                  rep_nxt  = '0;
                  held_nxt = q_color;
                end
                if (confirmed) begin
                  if (held_r == dcrs_pkg::COLOR_WHITE) begin
                    ref_nxt = q_pos;
                    if (first_r) begin
                      fin_nxt        = 1'b1;
                      emit           = 1'b1;
                      out_kind_nxt   = dcrs_pkg::EV_STOP;
                      out_color_nxt  = dcrs_pkg::COLOR_NONE;
                      out_blocks_nxt = '0;
                    end
                  end else if (changed && dcrs_pkg::is_run_color(held_r) &&
                               !diff[PB] && diff[PB-1:0] != '0) begin
                    start_div  = 1'b1;
                    quo_nxt    = diff[PB-1:0];
                    rem_nxt    = '0;
                    cnt_nxt    = '0;
                    div_nxt    = (tpb_r == '0) ? 16'd1 : tpb_r;
                    runc_nxt   = held_r;
                    endpos_nxt = q_pos;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      dcrs_pkg::BK_DIVIDE: begin
        rem_nxt = trial_ge ? 16'(trial - {1'b0, div_r}) : trial[15:0];
        quo_nxt = {quo_r[PB-2:0], trial_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      dcrs_pkg::BK_DONE: begin
        // zero blocks: dropped, state untouched
        if (quo_r != '0 && slot_free) begin
          first_nxt      = 1'b1;
          ref_nxt        = endpos_r;
          emit           = 1'b1;
          out_kind_nxt   = dcrs_pkg::EV_RUN;
          out_color_nxt  = runc_r;
          out_blocks_nxt = quo_sat ? dcrs_pkg::BLOCKS_MAX : quo_r[15:0];
        end
      end
      default: ;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.run_color  = out_color_r;
  assign out_ch.run_blocks = out_blocks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcrs_pkg::BK_IDLE;
      confirm_r   <= dcrs_pkg::CONFIRM_RESET;
      tpb_r       <= dcrs_pkg::TPB_RESET;
      held_r      <= dcrs_pkg::COLOR_NONE;
      rep_r       <= '0;
      ref_r       <= '0;
      first_r     <= 1'b0;
      fin_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      rep_r       <= rep_nxt;
      ref_r       <= ref_nxt;
      first_r     <= first_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dcrs_pkg::CFG_CONFIRM_COUNT:   confirm_r <= cfg_wdata[7:0];
          dcrs_pkg::CFG_TICKS_PER_BLOCK: tpb_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    runc_r       <= runc_nxt;
    endpos_r     <= endpos_nxt;
    out_kind_r   <= out_kind_nxt;
    out_color_r  <= out_color_nxt;
    out_blocks_r <= out_blocks_nxt;
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == dcrs_pkg::BK_IDLE)
    else $error("queue popped while a run is in the divider");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before it was taken");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dcrs_pkg::BK_DIVIDE |-> (div_r != '0 && rem_r < div_r))
    else $error("divider remainder out of range");

  a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcrs_pkg::BK_IDLE && start_div) |=> (state_r == dcrs_pkg::BK_DIVIDE
      && cnt_r == '0))
    else $error("divider did not start from step zero");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == dcrs_pkg::EV_RUN) |-> out_blocks_r != '0)
    else $error("run of zero blocks reported");
`endif

endmodule
`default_nettype wire

// ----- sv/debounced_color_run_segmenter.sv -----
// Top level: debounced color run segmenter, front decoder, queue and back processor.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | cmd, sample_color, position
//   out_ch   | out | valid/ready        | event_kind, run_color, run_blocks
//   cfg      | in  | cfg_we, no stall   | cfg_index, cfg_wdata
//
// A start, stop or non-run sample is handled in the idle state of the back end; a sample that
// closes a run goes on through the divide and done states of the one-bit-per-cycle span
// divider. The front takes a beat whenever the 2-entry queue has room.
// Synchronous active-low reset; no clearing pass. A result waiting on out_ch keeps the
// back end from taking the next queued beat; the queue absorbs input beats until full.
`default_nettype none
module debounced_color_run_segmenter #(
  parameter int unsigned POSITION_BITS = dcrs_pkg::POSITION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dcrs_in_if.sink                              in_ch,
  dcrs_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [dcrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ENTRY_W = $bits(dcrs_pkg::item_kind_t) + 3 + POSITION_BITS;

  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_space;
  logic               q_pop;
  logic               q_avail;
  logic [ENTRY_W-1:0] q_rdata;

  dcrs_front #(
    .POSITION_BITS (POSITION_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_front (
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_space (q_space)
  );

  dcrs_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (dcrs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .space     (q_space),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_rdata)
  );

  dcrs_back #(
    .POSITION_BITS (POSITION_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_avail   (q_avail),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for the color run segmenter: random beats, event prediction and checking.
`timescale 1ns / 1ps
module testbench;

  localparam int PW = dcrs_pkg::POSITION_BITS;
  // back end stays busy while a run beat is divided, plus the queued beats behind it
  localparam int SETTLE = 4 * (PW + 2);
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  hue;
    logic [15:0] blocks;
  } seg_event_t;

  // Tracks the segmenter state and holds the events it owes on the result channel.
  class run_event_book;
    seg_event_t due_events[$];
    logic [7:0] confirm_cnt;
    logic [15:0] tpb;
    logic [2:0] held;
    logic [7:0] repeats;
    logic signed [PW-1:0] ref_pos;
    bit first_sent;
    bit done;
    int mismatches;
    int starts_seen;
    int runs_seen;
    int stops_seen;

    function new();
      confirm_cnt = dcrs_pkg::CONFIRM_RESET;
      tpb = dcrs_pkg::TPB_RESET;
      held = dcrs_pkg::COLOR_NONE;
      repeats = '0;
      ref_pos = '0;
      first_sent = 0;
      done = 1;
    endfunction

    function void set_reg(logic [dcrs_pkg::CFG_IDX_W-1:0] idx,
                          logic [dcrs_pkg::CFG_DATA_W-1:0] val);
      if (idx == dcrs_pkg::CFG_CONFIRM_COUNT) confirm_cnt = val[7:0];
      else tpb = val;
    endfunction

    function int outstanding();
      return due_events.size();
    endfunction

    function void owe_event(seg_event_t ev);
      due_events.insert(due_events.size(), ev);
    endfunction

    function void take_beat(logic [1:0] cmd, logic [2:0] hue, logic [PW-1:0] pos);
      logic [2:0] was;
      bit confirmed;
      bit changed;
      logic [PW:0] span;
      logic [PW:0] divisor;
      logic [PW:0] quot;
      if (cmd == dcrs_pkg::CMD_START) begin
        held = dcrs_pkg::COLOR_NONE;
        repeats = '0;
        ref_pos = $signed(pos);
        first_sent = 0;
        done = 0;
        owe_event(seg_event_t'{dcrs_pkg::EV_START, dcrs_pkg::COLOR_WHITE,
                               dcrs_pkg::START_BLOCKS});
        return;
      end
      if (cmd == dcrs_pkg::CMD_STOP) begin
        if (!done) begin
          done = 1;
          owe_event(seg_event_t'{dcrs_pkg::EV_STOP, dcrs_pkg::COLOR_NONE, 16'd0});
        end
        return;
      end
      if (cmd != dcrs_pkg::CMD_SAMPLE || done) return;

      was = held;
      confirmed = repeats >= confirm_cnt;
      if (hue == held) begin
        if (repeats < confirm_cnt) repeats = repeats + 8'd1;
      end else begin
        repeats = '0;
        held = hue;
      end
      changed = held != was;
      if (!confirmed) return;

      if (was == dcrs_pkg::COLOR_WHITE) begin
        ref_pos = $signed(pos);
        if (first_sent) begin
          done = 1;
          owe_event(seg_event_t'{dcrs_pkg::EV_STOP, dcrs_pkg::COLOR_NONE, 16'd0});
          return;
        end
      end
      if (changed && (was == dcrs_pkg::COLOR_RED || was == dcrs_pkg::COLOR_GREEN ||
                      was == dcrs_pkg::COLOR_BLUE || was == dcrs_pkg::COLOR_YELLOW) &&
          $signed(pos) > ref_pos) begin
        span = {pos[PW-1], pos} - {ref_pos[PW-1], ref_pos};
        divisor = (tpb == 16'd0) ? (PW+1)'(1) : (PW+1)'(tpb);
        quot = span / divisor;
        if (quot != 0) begin
          first_sent = 1;
          ref_pos = $signed(pos);
          owe_event(seg_event_t'{dcrs_pkg::EV_RUN, was,
                    (quot > dcrs_pkg::BLOCKS_MAX) ? dcrs_pkg::BLOCKS_MAX : quot[15:0]});
        end
      end
    endfunction

    function void check_event(logic [1:0] kind, logic [2:0] hue, logic [15:0] blocks);
      seg_event_t want;
      if (due_events.size() == 0) begin
        mismatches++;
        $display("%0t: event with none expected: kind %0d color %0d blocks %0d",
                 $time, kind, hue, blocks);
        return;
      end
      want = due_events.pop_front();
      if (kind !== want.kind) begin
        mismatches++;
        $display("%0t: event_kind expected %0d, actual %0d", $time, want.kind, kind);
      end
      if (hue !== want.hue) begin
        mismatches++;
        $display("%0t: run_color expected %0d, actual %0d", $time, want.hue, hue);
      end
      if (blocks !== want.blocks) begin
        mismatches++;
        $display("%0t: run_blocks expected %0d, actual %0d", $time, want.blocks, blocks);
      end
      if (want.kind == dcrs_pkg::EV_START) starts_seen++;
      else if (want.kind == dcrs_pkg::EV_RUN) runs_seen++;
      else stops_seen++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [dcrs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dcrs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dcrs_in_if in_ch ();
  dcrs_out_if out_ch ();

  debounced_color_run_segmenter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  run_event_book book = new();

  logic [2:0] run_hues[4] = '{dcrs_pkg::COLOR_BLUE, dcrs_pkg::COLOR_GREEN,
                             dcrs_pkg::COLOR_YELLOW, dcrs_pkg::COLOR_RED};
  int cur_confirm;
  int cur_tpb;
  int in_odds;
  int out_odds;
  int hold_req;
  int beats_sent;
  int settings_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  // result side: check every beat, stall in bursts, honor a long hold request
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        book.check_event(out_ch.event_kind, out_ch.run_color, out_ch.run_blocks);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_odds != 0 && $urandom_range(out_odds - 1, 0) == 0)
          stall_left = $urandom_range(1, 18);
      end
    end
  end

  // valid stays high when the next beat follows at once
  task automatic send_item(input logic [1:0] cmd, input logic [2:0] hue,
                           input logic [PW-1:0] pos);
    int gap;
    gap = 0;
    if (in_odds != 0 && $urandom_range(in_odds - 1, 0) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.sample_color <= hue;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    book.take_beat(cmd, hue, pos);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (book.outstanding() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input int confirm, input int ticks);
    cfg_we <= 1'b1;
    cfg_index <= dcrs_pkg::CFG_CONFIRM_COUNT;
    cfg_wdata <= dcrs_pkg::CFG_DATA_W'(confirm);
    @(posedge clk);
    book.set_reg(dcrs_pkg::CFG_CONFIRM_COUNT, dcrs_pkg::CFG_DATA_W'(confirm));
    cfg_index <= dcrs_pkg::CFG_TICKS_PER_BLOCK;
    cfg_wdata <= dcrs_pkg::CFG_DATA_W'(ticks);
    @(posedge clk);
    book.set_reg(dcrs_pkg::CFG_TICKS_PER_BLOCK, dcrs_pkg::CFG_DATA_W'(ticks));
    cfg_we <= 1'b0;
    cur_confirm = confirm;
    cur_tpb = ticks;
    settings_done++;
  endtask

  // start, then color segments sized to give a chosen block count, then sometimes an ending
  task automatic run_sequence();
    logic [PW-1:0] pos;
    logic [2:0] hue;
    logic [63:0] seg_span;
    logic [63:0] step;
    int n_seg;
    int reps;
    int b;
    int r;
    int tpb_eff;
    tpb_eff = (cur_tpb == 0) ? 1 : cur_tpb;
    pos = ($urandom_range(0, 3) == 0) ? {1'b1, {(PW-1){1'b0}}} : PW'($urandom);
    send_item(dcrs_pkg::CMD_START, 3'($urandom), pos);
    n_seg = (cur_confirm > 30) ? 2 : $urandom_range(2, 8);
    for (int s = 0; s < n_seg; s++) begin
      r = $urandom_range(0, 15);
      if (r < 11) hue = run_hues[$urandom_range(0, 3)];
      else if (r < 14) hue = dcrs_pkg::COLOR_WHITE;
      else hue = 3'($urandom);
      reps = cur_confirm + $urandom_range(1, 3);
      if (cur_confirm > 30 && s > 0) reps = 2;
      else if ($urandom_range(0, 5) == 0) reps = $urandom_range(1, cur_confirm + 1);
      b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 40);
      seg_span = 64'(b) * 64'(tpb_eff) + 64'($urandom_range(0, tpb_eff - 1));
      if ($urandom_range(0, 15) == 0) seg_span = {32'd0, $urandom};
      step = seg_span / reps;
      for (int k = 0; k < reps; k++) begin
        // an occasional glitch sample breaks the debounce count
        if ($urandom_range(0, 39) == 0) send_item(dcrs_pkg::CMD_SAMPLE, 3'($urandom), pos);
        else send_item(dcrs_pkg::CMD_SAMPLE, hue, pos);
        pos = pos + step[PW-1:0];
      end
    end
    r = $urandom_range(0, 3);
    if ((r == 1 || r == 3) && cur_confirm <= 30) begin
      for (int k = 0; k < cur_confirm + 2; k++) begin
        send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_WHITE, pos);
        pos = pos + PW'($urandom_range(0, tpb_eff));
      end
    end
    if (r == 0 || r == 3) send_item(dcrs_pkg::CMD_STOP, 3'($urandom), PW'($urandom));
  endtask

  initial begin
    int ph_confirm[8];
    int ph_tpb[8];
    int ph_items[8];
    int stop_at;
    int c;
    int t;
    ph_confirm = '{3, 0, 1, 25, 2, 255, -1, 4};
    ph_tpb = '{90, 1, 65535, 90, 0, 300, -1, -1};
    ph_items = '{170, 140, 140, 130, 140, 240, 140, 140};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = dcrs_pkg::CMD_START;
    in_ch.sample_color = dcrs_pkg::COLOR_NONE;
    in_ch.position = '0;
    in_odds = 4;
    out_odds = 4;
    hold_req = 0;
    beats_sent = 0;
    settings_done = 0;
    cur_confirm = dcrs_pkg::CONFIRM_RESET;
    cur_tpb = dcrs_pkg::TPB_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle commands, restart, each run color, short and backward spans, white end
    set_config(2, 10);
    send_item(dcrs_pkg::CMD_STOP, dcrs_pkg::COLOR_NONE, '0);
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_RED, '0);
    send_item(CMD_UNUSED, dcrs_pkg::COLOR_WHITE, '1);
    send_item(dcrs_pkg::CMD_START, dcrs_pkg::COLOR_WHITE, {1'b1, {(PW-1){1'b0}}});
    send_item(dcrs_pkg::CMD_START, dcrs_pkg::COLOR_NONE, '0);
    repeat (3) send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_RED, PW'(5));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_GREEN, PW'(100));
    repeat (2) send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_GREEN, PW'(150));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_BLUE, PW'(155));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_BLUE, PW'(156));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_BLUE, PW'(157));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_YELLOW, PW'(160));
    repeat (2) send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_YELLOW, PW'(170));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_WHITE, PW'(140));
    repeat (2) send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_WHITE, PW'(200));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_WHITE, PW'(210));
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_RED, PW'(220));
    drain_results();
    // every sample confirmed, one tick per block, full-range span saturates
    set_config(0, 1);
    send_item(dcrs_pkg::CMD_START, dcrs_pkg::COLOR_NONE, {1'b1, {(PW-1){1'b0}}});
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_RED, {1'b1, {(PW-1){1'b0}}});
    send_item(dcrs_pkg::CMD_SAMPLE, dcrs_pkg::COLOR_GREEN, {1'b0, {(PW-1){1'b1}}});
    send_item(dcrs_pkg::CMD_STOP, dcrs_pkg::COLOR_NONE, '0);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      c = (ph_confirm[p] < 0) ? $urandom_range(1, 6) : ph_confirm[p];
      t = (ph_tpb[p] < 0) ? $urandom_range(1, (p == 7) ? 65535 : 2000) : ph_tpb[p];
      set_config(c, t);
      if (p == 7) begin
        in_odds = 0;
        out_odds = 0;
      end else begin
        in_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        out_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      end
      stop_at = beats_sent + ph_items[p];
      if (p == 0) begin
        // back-pressure: result side holds off while beats keep coming
        hold_req = 300;
        in_odds = 0;
        run_sequence();
        in_odds = 4;
      end
      while (beats_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4))
            send_item(2'($urandom), 3'($urandom), PW'($urandom));
        run_sequence();
      end
    end
    drain_results();

    $display("Ran %0d input beats under %0d register settings (confirm 0..255, block 0..65535).",
             beats_sent, settings_done);
    $display("Checked %0d start, %0d run and %0d stop events.",
             book.starts_seen, book.runs_seen, book.stops_seen);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
